[src/pfru_pkg.sv]
// ============================================================================
// pfru_pkg
// Shared types, codes and arithmetic helpers for the Poisson factor row
// update block.
// ============================================================================
package pfru_pkg;

    // Number of quotient bits the restoring divider produces
    localparam int DIV_STEPS = 48;

    // Input command codes
    typedef enum logic [2:0] {
        CMD_LOAD_FIXED = 3'd0,
        CMD_LOAD_ROW   = 3'd1,
        CMD_NONZERO    = 3'd2,
        CMD_PROCESS    = 3'd3,
        CMD_CLEAR_SUMS = 3'd4
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_K_USED     = 3'd0,
        REG_GRAD_STEP  = 3'd1,
        REG_SCALE_DIV  = 3'd2,
        REG_L1_PENALTY = 3'd3,
        REG_PASSES     = 3'd4
    } reg_idx_t;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD_FIXED,
        OP_LOAD_ROW,
        OP_NZ_APPEND,
        OP_CLEAR_SUMS,
        OP_PROC_START,
        OP_CT_MUL,
        OP_CT_WR,
        OP_GRAD_CLR,
        OP_NZ_RD,
        OP_FM_RD,
        OP_DOT_MUL,
        OP_DOT_ACC,
        OP_DOT_SAT,
        OP_ZD,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_Q_SAT,
        OP_GR_MUL,
        OP_GR_ACC,
        OP_UP_MUL,
        OP_UP_SUM,
        OP_UP_SMUL,
        OP_UP_WR,
        OP_EMIT
    } op_t;

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_CT_MUL,
        S_CT_WR,
        S_PASS_INIT,
        S_NZ_RD,
        S_DOT_RD,
        S_DOT_MUL,
        S_DOT_ACC,
        S_DOT_SAT,
        S_DIV_CHK,
        S_DIV_STEP,
        S_Q_SAT,
        S_GR_RD,
        S_GR_MUL,
        S_GR_ACC,
        S_UP_MUL,
        S_UP_SUM,
        S_UP_SMUL,
        S_UP_WR,
        S_EMIT
    } state_t;

    // Command from controller to datapath
    typedef struct packed {
        op_t  op;
        logic last;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic d_zero;
        logic out_free;
    } dp_stat_t;

    // Saturated Q16.16 value with clip flag
    typedef struct packed {
        logic        ovf;
        logic [31:0] v;
    } sat_t;

    // Sign-extend a 32-bit value to the working width
    function automatic logic signed [65:0] sx32(input logic signed [31:0] v);
        return {{34{v[31]}}, v};
    endfunction

    // Round half up and drop 16 fraction bits
    function automatic logic signed [65:0] rnd16(input logic signed [65:0] p);
        return (p + 66'sd32768) >>> 16;
    endfunction

    // Clip to the signed 32-bit range
    function automatic sat_t sat32(input logic signed [65:0] x);
        sat_t r;
        if (x > 66'sd2147483647) begin
            r.ovf = 1'b1;
            r.v   = 32'h7FFF_FFFF;
        end
        else if (x < -66'sd2147483648) begin
            r.ovf = 1'b1;
            r.v   = 32'h8000_0000;
        end
        else begin
            r.ovf = 1'b0;
            r.v   = x[31:0];
        end
        return r;
    endfunction

endpackage

[src/pfru_ctrl.sv]
// ============================================================================
// pfru_ctrl
// Controller: decodes input items, walks constants, passes, nonzeros and
// components, steps the divider and paces result emission.
// ============================================================================
module pfru_ctrl #(
    parameter  int K_MAX   = 16,
    parameter  int ROWS    = 4096,
    parameter  int NNZ_MAX = 256,
    localparam int K_W     = (K_MAX > 1) ? $clog2(K_MAX) : 1,
    localparam int NZ_W    = (NNZ_MAX > 1) ? $clog2(NNZ_MAX) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2:0]          command,
    input  logic [11:0]         fixed_row,
    input  logic [3:0]          component,
    input  logic [4:0]          k_used,
    input  logic [3:0]          passes,
    input  pfru_pkg::dp_stat_t  stat,
    output pfru_pkg::dp_cmd_t   dp_cmd,
    output logic [K_W-1:0]      comp_idx,
    output logic [NZ_W-1:0]     nz_addr
);

    localparam int KC_W   = $clog2(K_MAX + 1);
    localparam int NZC_W  = $clog2(NNZ_MAX + 1);
    localparam int STEP_W = $clog2(pfru_pkg::DIV_STEPS);

    pfru_pkg::state_t   state_reg, state_next;
    logic [KC_W-1:0]    j_reg, j_next;
    logic [NZC_W-1:0]   i_reg, i_next;
    logic [NZC_W-1:0]   cnt_reg, cnt_next;
    logic [3:0]         pass_reg, pass_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    logic [KC_W-1:0]    k_eff;
    logic [3:0]         np;
    logic               j_last;
    logic               nz_more;
    logic               pass_more;
    logic               accept;
    logic               row_ok;
    logic               comp_ok;
    logic               nz_room;

    // Clamp the component count and the pass count
    always_comb
    begin
        if (k_used == 5'd0)
        begin
            k_eff = KC_W'(1);
        end
        else if (7'(k_used) > 7'(K_MAX))
        begin
            k_eff = KC_W'(K_MAX);
        end
        else
        begin
            k_eff = KC_W'(k_used);
        end
        np = (passes == 4'd0) ? 4'd1 : passes;
    end

    assign j_last    = (j_reg == k_eff - KC_W'(1));
    assign nz_more   = (NZC_W'(i_reg + NZC_W'(1)) < cnt_reg);
    assign pass_more = (({1'b0, pass_reg} + 5'd1) < {1'b0, np});
    assign accept    = s_tvalid && s_tready;
    assign row_ok    = ({5'd0, fixed_row} < 17'(ROWS));
    assign comp_ok   = ({3'd0, component} < 7'(K_MAX));
    assign nz_room   = (cnt_reg < NZC_W'(NNZ_MAX));

    assign comp_idx = j_reg[K_W-1:0];
    assign nz_addr  = (state_reg == pfru_pkg::S_IDLE) ? cnt_reg[NZ_W-1:0]
                                                      : i_reg[NZ_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfru_pkg::S_IDLE:
            begin
                if (accept && command == pfru_pkg::CMD_PROCESS)
                begin
                    state_next = pfru_pkg::S_CT_MUL;
                end
            end
            pfru_pkg::S_CT_MUL:   state_next = pfru_pkg::S_CT_WR;
            pfru_pkg::S_CT_WR:
                state_next = j_last ? pfru_pkg::S_PASS_INIT : pfru_pkg::S_CT_MUL;
            pfru_pkg::S_PASS_INIT:
                state_next = (cnt_reg == '0) ? pfru_pkg::S_UP_MUL : pfru_pkg::S_NZ_RD;
            pfru_pkg::S_NZ_RD:    state_next = pfru_pkg::S_DOT_RD;
            pfru_pkg::S_DOT_RD:   state_next = pfru_pkg::S_DOT_MUL;
            pfru_pkg::S_DOT_MUL:  state_next = pfru_pkg::S_DOT_ACC;
            pfru_pkg::S_DOT_ACC:
                state_next = j_last ? pfru_pkg::S_DOT_SAT : pfru_pkg::S_DOT_RD;
            pfru_pkg::S_DOT_SAT:  state_next = pfru_pkg::S_DIV_CHK;
            pfru_pkg::S_DIV_CHK:
            begin
                if (stat.d_zero)
                begin
                    state_next = nz_more ? pfru_pkg::S_NZ_RD : pfru_pkg::S_UP_MUL;
                end
                else
                begin
                    state_next = pfru_pkg::S_DIV_STEP;
                end
            end
            pfru_pkg::S_DIV_STEP:
            begin
                if (step_reg == STEP_W'(pfru_pkg::DIV_STEPS - 1))
                begin
                    state_next = pfru_pkg::S_Q_SAT;
                end
            end
            pfru_pkg::S_Q_SAT:    state_next = pfru_pkg::S_GR_RD;
            pfru_pkg::S_GR_RD:    state_next = pfru_pkg::S_GR_MUL;
            pfru_pkg::S_GR_MUL:   state_next = pfru_pkg::S_GR_ACC;
            pfru_pkg::S_GR_ACC:
            begin
                if (j_last)
                begin
                    state_next = nz_more ? pfru_pkg::S_NZ_RD : pfru_pkg::S_UP_MUL;
                end
                else
                begin
                    state_next = pfru_pkg::S_GR_RD;
                end
            end
            pfru_pkg::S_UP_MUL:   state_next = pfru_pkg::S_UP_SUM;
            pfru_pkg::S_UP_SUM:   state_next = pfru_pkg::S_UP_SMUL;
            pfru_pkg::S_UP_SMUL:  state_next = pfru_pkg::S_UP_WR;
            pfru_pkg::S_UP_WR:
            begin
                if (j_last)
                begin
                    state_next = pass_more ? pfru_pkg::S_PASS_INIT : pfru_pkg::S_EMIT;
                end
                else
                begin
                    state_next = pfru_pkg::S_UP_MUL;
                end
            end
            pfru_pkg::S_EMIT:
            begin
                if (stat.out_free && j_last)
                begin
                    state_next = pfru_pkg::S_IDLE;
                end
            end
            default:              state_next = pfru_pkg::S_IDLE;
        endcase
    end

    // Outputs and counter updates
    always_comb
    begin
        s_tready    = 1'b0;
        dp_cmd.op   = pfru_pkg::OP_NONE;
        dp_cmd.last = 1'b0;
        j_next      = j_reg;
        i_next      = i_reg;
        cnt_next    = cnt_reg;
        pass_next   = pass_reg;
        step_next   = step_reg;
        unique case (state_reg)
            pfru_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    case (command)
                        pfru_pkg::CMD_LOAD_FIXED:
                        begin
                            if (row_ok && comp_ok)
                            begin
                                dp_cmd.op = pfru_pkg::OP_LOAD_FIXED;
                            end
                        end
                        pfru_pkg::CMD_LOAD_ROW:
                        begin
                            if (comp_ok)
                            begin
                                dp_cmd.op = pfru_pkg::OP_LOAD_ROW;
                            end
                        end
                        pfru_pkg::CMD_NONZERO:
                        begin
                            if (row_ok && nz_room)
                            begin
                                dp_cmd.op = pfru_pkg::OP_NZ_APPEND;
                                cnt_next  = cnt_reg + NZC_W'(1);
                            end
                        end
                        pfru_pkg::CMD_PROCESS:
                        begin
                            dp_cmd.op = pfru_pkg::OP_PROC_START;
                            j_next    = '0;
                        end
                        pfru_pkg::CMD_CLEAR_SUMS:
                        begin
                            dp_cmd.op = pfru_pkg::OP_CLEAR_SUMS;
                        end
                        default:
                        begin
                            dp_cmd.op = pfru_pkg::OP_NONE;
                        end
                    endcase
                end
            end
            pfru_pkg::S_CT_MUL:
            begin
                dp_cmd.op = pfru_pkg::OP_CT_MUL;
            end
            pfru_pkg::S_CT_WR:
            begin
                dp_cmd.op = pfru_pkg::OP_CT_WR;
                if (j_last)
                begin
                    j_next    = '0;
                    pass_next = '0;
                end
                else
                begin
                    j_next = j_reg + KC_W'(1);
                end
            end
            pfru_pkg::S_PASS_INIT:
            begin
                dp_cmd.op = pfru_pkg::OP_GRAD_CLR;
                i_next    = '0;
                j_next    = '0;
            end
            pfru_pkg::S_NZ_RD:
            begin
                dp_cmd.op = pfru_pkg::OP_NZ_RD;
                j_next    = '0;
            end
            pfru_pkg::S_DOT_RD:
            begin
                dp_cmd.op = pfru_pkg::OP_FM_RD;
            end
            pfru_pkg::S_DOT_MUL:
            begin
                dp_cmd.op = pfru_pkg::OP_DOT_MUL;
            end
            pfru_pkg::S_DOT_ACC:
            begin
                dp_cmd.op = pfru_pkg::OP_DOT_ACC;
                if (!j_last)
                begin
                    j_next = j_reg + KC_W'(1);
                end
            end
            pfru_pkg::S_DOT_SAT:
            begin
                dp_cmd.op = pfru_pkg::OP_DOT_SAT;
            end
            pfru_pkg::S_DIV_CHK:
            begin
                j_next = '0;
                if (stat.d_zero)
                begin
                    // Skip this nonzero's term
                    dp_cmd.op = pfru_pkg::OP_ZD;
                    if (nz_more)
                    begin
                        i_next = i_reg + NZC_W'(1);
                    end
                end
                else
                begin
                    dp_cmd.op = pfru_pkg::OP_DIV_LOAD;
                    step_next = '0;
                end
            end
            pfru_pkg::S_DIV_STEP:
            begin
                dp_cmd.op = pfru_pkg::OP_DIV_STEP;
                step_next = step_reg + STEP_W'(1);
            end
            pfru_pkg::S_Q_SAT:
            begin
                dp_cmd.op = pfru_pkg::OP_Q_SAT;
                j_next    = '0;
            end
            pfru_pkg::S_GR_RD:
            begin
                dp_cmd.op = pfru_pkg::OP_FM_RD;
            end
            pfru_pkg::S_GR_MUL:
            begin
                dp_cmd.op = pfru_pkg::OP_GR_MUL;
            end
            pfru_pkg::S_GR_ACC:
            begin
                dp_cmd.op = pfru_pkg::OP_GR_ACC;
                if (j_last)
                begin
                    j_next = '0;
                    if (nz_more)
                    begin
                        i_next = i_reg + NZC_W'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + KC_W'(1);
                end
            end
            pfru_pkg::S_UP_MUL:
            begin
                dp_cmd.op = pfru_pkg::OP_UP_MUL;
            end
            pfru_pkg::S_UP_SUM:
            begin
                dp_cmd.op = pfru_pkg::OP_UP_SUM;
            end
            pfru_pkg::S_UP_SMUL:
            begin
                dp_cmd.op = pfru_pkg::OP_UP_SMUL;
            end
            pfru_pkg::S_UP_WR:
            begin
                dp_cmd.op = pfru_pkg::OP_UP_WR;
                if (j_last)
                begin
                    j_next = '0;
                    if (pass_more)
                    begin
                        pass_next = pass_reg + 4'd1;
                    end
                end
                else
                begin
                    j_next = j_reg + KC_W'(1);
                end
            end
            pfru_pkg::S_EMIT:
            begin
                if (stat.out_free)
                begin
                    dp_cmd.op   = pfru_pkg::OP_EMIT;
                    dp_cmd.last = j_last;
                    if (j_last)
                    begin
                        // Row done: empty the nonzero list
                        j_next   = '0;
                        cnt_next = '0;
                    end
                    else
                    begin
                        j_next = j_reg + KC_W'(1);
                    end
                end
            end
            default:
            begin
                dp_cmd.op = pfru_pkg::OP_NONE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfru_pkg::S_IDLE;
            j_reg     <= '0;
            i_reg     <= '0;
            cnt_reg   <= '0;
            pass_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            i_reg     <= i_next;
            cnt_reg   <= cnt_next;
            pass_reg  <= pass_next;
            step_reg  <= step_next;
        end
    end

endmodule

[src/pfru_dp.sv]
// ============================================================================
// pfru_dp
// Datapath: factor and nonzero memories, column sums, row and gradient
// registers, one shared 33x33 multiplier, restoring divider, output register.
// ============================================================================
module pfru_dp #(
    parameter  int K_MAX   = 16,
    parameter  int ROWS    = 4096,
    parameter  int NNZ_MAX = 256,
    localparam int K_W     = (K_MAX > 1) ? $clog2(K_MAX) : 1,
    localparam int NZ_W    = (NNZ_MAX > 1) ? $clog2(NNZ_MAX) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pfru_pkg::dp_cmd_t   dp_cmd,
    output pfru_pkg::dp_stat_t  stat,
    input  logic [K_W-1:0]      comp_idx,
    input  logic [NZ_W-1:0]     nz_addr,
    input  logic [11:0]         fixed_row,
    input  logic [3:0]          component,
    input  logic [31:0]         value,
    input  logic [30:0]         grad_step,
    input  logic [16:0]         scale_div,
    input  logic [30:0]         l1_penalty,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [3:0]          out_component,
    output logic [31:0]         out_value,
    output logic                out_last,
    output logic                out_saturated,
    output logic                out_zero_divisor
);

    localparam int FM_DEPTH = ROWS * K_MAX;
    localparam int FA_W     = (FM_DEPTH > 1) ? $clog2(FM_DEPTH) : 1;

    // Storage
    logic [31:0]        fmem_mem   [FM_DEPTH];
    logic [11:0]        nzi_mem    [NNZ_MAX];
    logic [31:0]        nzv_mem    [NNZ_MAX];
    logic [31:0]        colsum_reg [K_MAX];
    logic [31:0]        row_reg    [K_MAX];
    logic [31:0]        grad_reg   [K_MAX];
    logic [31:0]        cterm_reg  [K_MAX];

    logic               sum_sat_reg;
    logic               row_sat_reg;
    logic               zd_reg;
    logic [31:0]        fm_q_reg;
    logic [11:0]        nz_idx_q_reg;
    logic [31:0]        nz_val_q_reg;
    logic signed [65:0] prod_reg;
    logic signed [53:0] dot_reg;
    logic [31:0]        d_reg;
    logic [31:0]        q_reg;
    logic [31:0]        t_reg;
    logic [47:0]        num_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        den_reg;
    logic               qneg_reg;
    logic               m_tvalid_reg;

    logic [K_W-1:0]     ld_k;
    logic [FA_W-1:0]    fm_waddr;
    logic [FA_W-1:0]    fm_raddr;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic               mul_en;
    logic signed [65:0] rnd_val;
    logic signed [65:0] q_mag_s;
    logic [31:0]        val_mag;
    logic [31:0]        d_mag;
    logic [32:0]        rem_sh;
    logic               rem_ge;
    logic [32:0]        rem_diff;
    pfru_pkg::sat_t     ld_sum;
    pfru_pkg::sat_t     ct_sum;
    pfru_pkg::sat_t     ct_val;
    pfru_pkg::sat_t     dot_d;
    pfru_pkg::sat_t     q_sat;
    pfru_pkg::sat_t     gr_sum;
    pfru_pkg::sat_t     up_sum;
    pfru_pkg::sat_t     up_r;

    assign ld_k     = K_W'(component);
    assign fm_waddr = FA_W'(32'(fixed_row) * 32'(K_MAX) + 32'(component));
    assign fm_raddr = FA_W'(32'(nz_idx_q_reg) * 32'(K_MAX) + 32'(comp_idx));

    // Saturating sums and rounded products
    assign rnd_val = pfru_pkg::rnd16(prod_reg);
    assign ld_sum  = pfru_pkg::sat32(pfru_pkg::sx32(colsum_reg[ld_k]) +
                                     pfru_pkg::sx32(value));
    assign ct_sum  = pfru_pkg::sat32(pfru_pkg::sx32(colsum_reg[comp_idx]) +
                                     {35'd0, l1_penalty});
    assign ct_val  = pfru_pkg::sat32(-rnd_val);
    assign dot_d   = pfru_pkg::sat32({{12{dot_reg[53]}}, dot_reg});
    assign gr_sum  = pfru_pkg::sat32(pfru_pkg::sx32(grad_reg[comp_idx]) + rnd_val);
    assign up_sum  = pfru_pkg::sat32(pfru_pkg::sx32(row_reg[comp_idx]) + rnd_val +
                                     pfru_pkg::sx32(cterm_reg[comp_idx]));
    assign up_r    = pfru_pkg::sat32(rnd_val);
    assign q_mag_s = {18'd0, num_reg};
    assign q_sat   = pfru_pkg::sat32(qneg_reg ? -q_mag_s : q_mag_s);

    // Divider operands and one restoring step
    assign val_mag  = nz_val_q_reg[31] ? (32'd0 - nz_val_q_reg) : nz_val_q_reg;
    assign d_mag    = d_reg[31] ? (32'd0 - d_reg) : d_reg;
    assign rem_sh   = {rem_reg, num_reg[47]};
    assign rem_ge   = (rem_sh >= {1'b0, den_reg});
    assign rem_diff = rem_sh - {1'b0, den_reg};

    // Select multiplier operands
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (dp_cmd.op)
            pfru_pkg::OP_CT_MUL:
            begin
                mul_a = {2'b00, grad_step};
                mul_b = {ct_sum.v[31], ct_sum.v};
            end
            pfru_pkg::OP_DOT_MUL:
            begin
                mul_a = {fm_q_reg[31], fm_q_reg};
                mul_b = {row_reg[comp_idx][31], row_reg[comp_idx]};
            end
            pfru_pkg::OP_GR_MUL:
            begin
                mul_a = {q_reg[31], q_reg};
                mul_b = {fm_q_reg[31], fm_q_reg};
            end
            pfru_pkg::OP_UP_MUL:
            begin
                mul_a = {2'b00, grad_step};
                mul_b = {grad_reg[comp_idx][31], grad_reg[comp_idx]};
            end
            pfru_pkg::OP_UP_SMUL:
            begin
                mul_a = {t_reg[31], t_reg};
                mul_b = {16'd0, scale_div};
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Register the product
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // Factor memory: write on load, registered read
    always_ff @(posedge clk)
    begin
        if (dp_cmd.op == pfru_pkg::OP_LOAD_FIXED)
        begin
            fmem_mem[fm_waddr] <= value;
        end
        if (dp_cmd.op == pfru_pkg::OP_FM_RD)
        begin
            fm_q_reg <= fmem_mem[fm_raddr];
        end
    end

    // Nonzero list: append at the fill count, registered read
    always_ff @(posedge clk)
    begin
        if (dp_cmd.op == pfru_pkg::OP_NZ_APPEND)
        begin
            nzi_mem[nz_addr] <= fixed_row;
            nzv_mem[nz_addr] <= value;
        end
        if (dp_cmd.op == pfru_pkg::OP_NZ_RD)
        begin
            nz_idx_q_reg <= nzi_mem[nz_addr];
            nz_val_q_reg <= nzv_mem[nz_addr];
        end
    end

    // Column sums and their saturation flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < K_MAX; n++)
            begin
                colsum_reg[n] <= '0;
            end
            sum_sat_reg <= 1'b0;
        end
        else
        begin
            case (dp_cmd.op)
                pfru_pkg::OP_LOAD_FIXED:
                begin
                    colsum_reg[ld_k] <= ld_sum.v;
                    sum_sat_reg      <= sum_sat_reg | ld_sum.ovf;
                end
                pfru_pkg::OP_CLEAR_SUMS:
                begin
                    for (int n = 0; n < K_MAX; n++)
                    begin
                        colsum_reg[n] <= '0;
                    end
                    sum_sat_reg <= 1'b0;
                end
                default:
                begin
                    sum_sat_reg <= sum_sat_reg;
                end
            endcase
        end
    end

    // Row-level flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_sat_reg <= 1'b0;
            zd_reg      <= 1'b0;
        end
        else
        begin
            case (dp_cmd.op)
                pfru_pkg::OP_PROC_START:
                begin
                    row_sat_reg <= sum_sat_reg;
                    zd_reg      <= 1'b0;
                end
                pfru_pkg::OP_CT_MUL:  row_sat_reg <= row_sat_reg | ct_sum.ovf;
                pfru_pkg::OP_CT_WR:   row_sat_reg <= row_sat_reg | ct_val.ovf;
                pfru_pkg::OP_DOT_SAT: row_sat_reg <= row_sat_reg | dot_d.ovf;
                pfru_pkg::OP_Q_SAT:   row_sat_reg <= row_sat_reg | q_sat.ovf;
                pfru_pkg::OP_GR_ACC:  row_sat_reg <= row_sat_reg | gr_sum.ovf;
                pfru_pkg::OP_UP_SUM:  row_sat_reg <= row_sat_reg | up_sum.ovf;
                pfru_pkg::OP_UP_WR:   row_sat_reg <= row_sat_reg | up_r.ovf;
                pfru_pkg::OP_ZD:      zd_reg      <= 1'b1;
                default:              zd_reg      <= zd_reg;
            endcase
        end
    end

    // Row, gradient, constant terms and arithmetic working registers
    always_ff @(posedge clk)
    begin
        case (dp_cmd.op)
            pfru_pkg::OP_LOAD_ROW:
            begin
                row_reg[ld_k] <= value;
            end
            pfru_pkg::OP_CT_WR:
            begin
                cterm_reg[comp_idx] <= ct_val.v;
            end
            pfru_pkg::OP_GRAD_CLR:
            begin
                for (int n = 0; n < K_MAX; n++)
                begin
                    grad_reg[n] <= '0;
                end
            end
            pfru_pkg::OP_NZ_RD:
            begin
                dot_reg <= '0;
            end
            pfru_pkg::OP_DOT_ACC:
            begin
                dot_reg <= dot_reg + rnd_val[53:0];
            end
            pfru_pkg::OP_DOT_SAT:
            begin
                d_reg <= dot_d.v;
            end
            pfru_pkg::OP_DIV_LOAD:
            begin
                num_reg  <= {val_mag, 16'd0};
                den_reg  <= d_mag;
                rem_reg  <= '0;
                qneg_reg <= nz_val_q_reg[31] ^ d_reg[31];
            end
            pfru_pkg::OP_DIV_STEP:
            begin
                rem_reg <= rem_ge ? rem_diff[31:0] : rem_sh[31:0];
                num_reg <= {num_reg[46:0], rem_ge};
            end
            pfru_pkg::OP_Q_SAT:
            begin
                q_reg <= q_sat.v;
            end
            pfru_pkg::OP_GR_ACC:
            begin
                grad_reg[comp_idx] <= gr_sum.v;
            end
            pfru_pkg::OP_UP_SUM:
            begin
                t_reg <= up_sum.v;
            end
            pfru_pkg::OP_UP_WR:
            begin
                // Clamp negatives to zero
                row_reg[comp_idx] <= up_r.v[31] ? 32'd0 : up_r.v;
            end
            default:
            begin
                t_reg <= t_reg;
            end
        endcase
    end

    // Output register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (dp_cmd.op == pfru_pkg::OP_EMIT)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.op == pfru_pkg::OP_EMIT)
        begin
            out_component    <= 4'(comp_idx);
            out_value        <= row_reg[comp_idx];
            out_last         <= dp_cmd.last;
            out_saturated    <= row_sat_reg;
            out_zero_divisor <= zd_reg;
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign stat.d_zero   = (d_reg == 32'd0);

endmodule

[src/poisson_factor_row_update_top.sv]
// ============================================================================
// poisson_factor_row_update_top
// Poisson factor row update: loads a fixed factor matrix with column sums,
// then runs proximal-gradient passes over one row and streams it out.
// ============================================================================
// Load, nonzero and clear items may arrive every cycle while idle. A process
// item computes the constant terms, then per pass walks each nonzero (dot
// product, then divide and gradient unless the product is zero), updates the
// row using the shared multiplier and one-bit-a-cycle divider, emits k items.
// No input is taken while a row is processed. Reset (rst_n, async, active low)
// resets sums, flags, counts and config; factor memory and row are undefined.
module poisson_factor_row_update_top #(
    parameter int K_MAX   = 16,
    parameter int ROWS    = 4096,
    parameter int NNZ_MAX = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // command[2:0], fixed_row[14:3], component[18:15],
                                   // value[50:19], zero[55:51]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_component[3:0], out_value[35:4], zero[39:36]
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // saturated[0], zero_divisor[1]
);

    localparam int K_W  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int NZ_W = (NNZ_MAX > 1) ? $clog2(NNZ_MAX) : 1;

    logic [4:0]            k_used_reg;
    logic [30:0]           grad_step_reg;
    logic [16:0]           scale_div_reg;
    logic [30:0]           l1_penalty_reg;
    logic [3:0]            passes_reg;
    logic                  cfg_wr;

    pfru_pkg::dp_cmd_t     dp_cmd;
    pfru_pkg::dp_stat_t    dp_stat;
    logic [K_W-1:0]        comp_idx;
    logic [NZ_W-1:0]       nz_addr;
    logic [3:0]            out_component;
    logic [31:0]           out_value;
    logic                  out_saturated;
    logic                  out_zero_divisor;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_used_reg     <= 5'd16;
            grad_step_reg  <= 31'd65536;
            scale_div_reg  <= 17'd65536;
            l1_penalty_reg <= 31'd0;
            passes_reg     <= 4'd1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                pfru_pkg::REG_K_USED:     k_used_reg     <= pwdata[4:0];
                pfru_pkg::REG_GRAD_STEP:  grad_step_reg  <= pwdata[30:0];
                pfru_pkg::REG_SCALE_DIV:  scale_div_reg  <= pwdata[16:0];
                pfru_pkg::REG_L1_PENALTY: l1_penalty_reg <= pwdata[30:0];
                pfru_pkg::REG_PASSES:     passes_reg     <= pwdata[3:0];
                default:                  passes_reg     <= passes_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (paddr[4:2])
            pfru_pkg::REG_K_USED:     prdata = {27'd0, k_used_reg};
            pfru_pkg::REG_GRAD_STEP:  prdata = {1'b0, grad_step_reg};
            pfru_pkg::REG_SCALE_DIV:  prdata = {15'd0, scale_div_reg};
            pfru_pkg::REG_L1_PENALTY: prdata = {1'b0, l1_penalty_reg};
            pfru_pkg::REG_PASSES:     prdata = {28'd0, passes_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    pfru_ctrl #(
        .K_MAX   (K_MAX),
        .ROWS    (ROWS),
        .NNZ_MAX (NNZ_MAX)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .command   (s_tdata[2:0]),
        .fixed_row (s_tdata[14:3]),
        .component (s_tdata[18:15]),
        .k_used    (k_used_reg),
        .passes    (passes_reg),
        .stat      (dp_stat),
        .dp_cmd    (dp_cmd),
        .comp_idx  (comp_idx),
        .nz_addr   (nz_addr)
    );

    pfru_dp #(
        .K_MAX   (K_MAX),
        .ROWS    (ROWS),
        .NNZ_MAX (NNZ_MAX)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .dp_cmd           (dp_cmd),
        .stat             (dp_stat),
        .comp_idx         (comp_idx),
        .nz_addr          (nz_addr),
        .fixed_row        (s_tdata[14:3]),
        .component        (s_tdata[18:15]),
        .value            (s_tdata[50:19]),
        .grad_step        (grad_step_reg),
        .scale_div        (scale_div_reg),
        .l1_penalty       (l1_penalty_reg),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .out_component    (out_component),
        .out_value        (out_value),
        .out_last         (m_tlast),
        .out_saturated    (out_saturated),
        .out_zero_divisor (out_zero_divisor)
    );

    // Pack the result item
    assign m_tdata = {4'd0, out_value, out_component};
    assign m_tuser = {out_zero_divisor, out_saturated};

`ifndef SYNTHESIS
    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.op == pfru_pkg::OP_EMIT) |-> (!m_tvalid || m_tready))
        else $error("result loaded over an item not yet taken");

    a_out_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[35])
        else $error("negative row element emitted");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.op == pfru_pkg::OP_DIV_STEP) |-> !s_tready)
        else $error("input accepted while dividing");
`endif

endmodule
